>>> hw/rtl/joint_ramp_setpoint_sequencer_top_assert.svh
// Assertion macros for the joint ramp setpoint sequencer.
`ifndef JOINT_RAMP_SETPOINT_SEQUENCER_TOP_ASSERT_SVH
`define JOINT_RAMP_SETPOINT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JRSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jrss_pkg.sv
`timescale 1ns / 1ps
package jrss_pkg;

    localparam int JOINTS   = 7;
    localparam int ARMS     = 2;
    localparam int POS_BITS = 20;
    localparam int SLOTS    = ARMS * JOINTS;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 21;
    localparam int TICK_W   = 20;
    localparam int TOL_W    = 19;
    localparam int ALPHA_W  = 17;

    localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'h10000;

    // Request types.
    localparam logic [1:0] REQ_FEEDBACK = 2'd0;
    localparam logic [1:0] REQ_TICK     = 2'd1;
    localparam logic [1:0] REQ_TARGET   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_COMMAND = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_SUCCESS = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HOLD    = 3'd0;
    localparam logic [2:0] CFG_MOVE    = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_TOL     = 3'd3;
    localparam logic [2:0] CFG_ARM_EN  = 3'd4;
    localparam logic [2:0] CFG_EXIT    = 3'd5;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic                       arm;
        logic [2:0]                 joint;
        logic signed [POS_BITS-1:0] position;
        logic                       last;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                 result_kind;
        logic                       out_arm;
        logic [2:0]                 out_joint;
        logic signed [POS_BITS-1:0] command_position;
        logic                       arm_done;
        logic                       last_result;
    } out_word_t;

endpackage

>>> hw/rtl/jrss_div.sv
`timescale 1ns / 1ps
// Restoring divider for alpha = num * 65536 / den, with num <= den.
// One quotient bit per cycle.
module jrss_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [19:0] num,
    input  logic [19:0] den,
    output logic        busy,
    output logic        done,
    output logic [16:0] quot
);
    import jrss_pkg::*;

    logic [19:0] rem_reg, rem_next;
    logic [16:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [20:0] trial;
    logic        fits;

    // Shift the partial remainder and try one subtraction.
    always_comb
    begin
        trial = {rem_reg, 1'b0};
        fits  = trial >= {1'b0, den};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // Top quotient bit is set only when the ramp is complete.
            quot_next = {(num == den), 16'h0000};
            rem_next  = (num == den) ? 20'h00000 : num;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? 20'(trial - {1'b0, den}) : trial[19:0];
            quot_next = {quot_reg[16], quot_reg[14:0], fits};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> hw/rtl/joint_ramp_setpoint_sequencer_top.sv
`timescale 1ns / 1ps
// Feedback words, target words and ticks that raise a timeout are handled in the idle state.
// A motion tick runs the tolerance scan over every slot beside the alpha divider; once
// alpha is ready, each enabled arm's commands are formed in S_MUL and sent from S_OUT,
// which waits while the output is stalled, and a success report follows when due.
// Throughput is one word per tick sequence; no new word is taken until the last result leaves.
// Reset (rst_n low, asynchronous) restores the register defaults and clears the current,
// start and target positions; the staging store is left as it is.
module joint_ramp_setpoint_sequencer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  jrss_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output jrss_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data
);
    import jrss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DIVW = 3'd2;
    localparam logic [2:0] S_NEXT = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_SUCC = 3'd6;

    // Configuration registers.
    logic [TICK_W-1:0] hold_reg, move_reg, timeout_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [ARMS-1:0]   arm_en_reg;
    logic              exit_reg;

    // Position stores.
    logic signed [POS_BITS-1:0] staged_reg  [SLOTS];
    logic signed [POS_BITS-1:0] current_reg [SLOTS];
    logic signed [POS_BITS-1:0] start_reg   [SLOTS];
    logic signed [POS_BITS-1:0] target_reg  [SLOTS];

    // Sequencer state.
    logic [2:0]         state_reg;
    logic [1:0]         arm_reg;
    logic [2:0]         joint_reg;
    logic [ARMS-1:0]    seen_reg, tol_ok_reg, done_reg;
    logic               begun_reg, timeout_sent_reg, success_sent_reg, halted_reg;
    logic               succ_emit_reg;
    logic [CNT_W-1:0]   wait_reg, motion_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               alpha_ok_reg;
    logic signed [POS_BITS+ALPHA_W+1:0] prod_reg;
    logic signed [POS_BITS-1:0]         s_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    // Accept and tick decode.
    logic             in_acc, is_fb, is_tgt, is_tick, slot_ok, waiting, out_free;
    logic [SLOT_W-1:0] in_slot, cur_slot;
    logic [CNT_W-1:0] wait_inc, elapsed, me_raw;
    logic [TICK_W-1:0] me_c;
    logic             div_start, div_busy, div_done;
    logic [ALPHA_W-1:0] div_q;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign slot_ok  = in_word.joint < 3'(JOINTS);
    assign in_slot  = SLOT_W'(in_word.arm) * SLOT_W'(JOINTS) + SLOT_W'(in_word.joint);
    assign cur_slot = SLOT_W'(arm_reg[0]) * SLOT_W'(JOINTS) + SLOT_W'(joint_reg);
    assign is_fb    = in_acc && !halted_reg && (in_word.req_type == REQ_FEEDBACK);
    assign is_tgt   = in_acc && !halted_reg && (in_word.req_type == REQ_TARGET);
    assign is_tick  = in_acc && !halted_reg && (in_word.req_type == REQ_TICK);
    assign waiting  = |(arm_en_reg & ~seen_reg);
    assign wait_inc = (wait_reg == COUNT_MAX) ? wait_reg : wait_reg + CNT_W'(1);

    // Ramp position before the divide.
    always_comb
    begin
        elapsed = begun_reg ? motion_reg : '0;
        me_raw  = (elapsed > {1'b0, hold_reg}) ? elapsed - {1'b0, hold_reg} : '0;
        me_c    = (me_raw > {1'b0, move_reg}) ? move_reg : me_raw[TICK_W-1:0];
    end

    assign div_start = is_tick && !waiting && (move_reg != '0);

    jrss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (me_c),
        .den   (move_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= 20'd25;
            move_reg    <= 20'd250;
            timeout_reg <= 20'd1500;
            tol_reg     <= 19'd1311;
            arm_en_reg  <= 2'b11;
            exit_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOLD:    hold_reg    <= cfg_data;
                CFG_MOVE:    move_reg    <= cfg_data;
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_TOL:     tol_reg     <= cfg_data[TOL_W-1:0];
                CFG_ARM_EN:  arm_en_reg  <= cfg_data[ARMS-1:0];
                CFG_EXIT:    exit_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Staging store: no reset, written by feedback words.
    always_ff @(posedge clk)
    begin
        if (is_fb && slot_ok)
            staged_reg[in_slot] <= in_word.position;
    end

    // Current, start and target stores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                current_reg[k] <= '0;
                start_reg[k]   <= '0;
                target_reg[k]  <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                // Commit the arm's staged set, including the word being taken.
                if (is_fb && in_word.last && (k / JOINTS == int'(in_word.arm)))
                begin
                    if (slot_ok && (k == int'(in_slot)))
                        current_reg[k] <= in_word.position;
                    else
                        current_reg[k] <= staged_reg[k];
                end
                // Capture the start pose when motion begins.
                if (is_tick && !waiting && !begun_reg && arm_en_reg[k / JOINTS])
                    start_reg[k] <= current_reg[k];
            end
            if (is_tgt && slot_ok)
                target_reg[in_slot] <= in_word.position;
        end
    end

    // Tolerance check and command arithmetic for the selected slot.
    logic signed [POS_BITS:0]   err, diff;
    logic [POS_BITS:0]          err_abs;
    logic signed [POS_BITS+ALPHA_W+1:0] rnd, shf;
    logic                       last_arm;

    always_comb
    begin
        err      = {current_reg[cur_slot][POS_BITS-1], current_reg[cur_slot]}
                   - {target_reg[cur_slot][POS_BITS-1], target_reg[cur_slot]};
        err_abs  = err[POS_BITS] ? (POS_BITS+1)'(-err) : err;
        diff     = {target_reg[cur_slot][POS_BITS-1], target_reg[cur_slot]}
                   - {start_reg[cur_slot][POS_BITS-1], start_reg[cur_slot]};
        rnd      = prod_reg + (POS_BITS+ALPHA_W+2)'(32768);
        shf      = rnd >>> 16;
        last_arm = (arm_reg[0] == 1'b1) || !arm_en_reg[1];
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            arm_reg          <= '0;
            joint_reg        <= '0;
            seen_reg         <= '0;
            tol_ok_reg       <= '0;
            done_reg         <= '0;
            begun_reg        <= 1'b0;
            timeout_sent_reg <= 1'b0;
            success_sent_reg <= 1'b0;
            halted_reg       <= 1'b0;
            succ_emit_reg    <= 1'b0;
            wait_reg         <= '0;
            motion_reg       <= '0;
            alpha_ok_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (div_done)
                alpha_ok_reg <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (is_fb && in_word.last)
                        seen_reg[in_word.arm] <= 1'b1;
                    if (is_tick && waiting)
                    begin
                        wait_reg <= wait_inc;
                        if (!timeout_sent_reg && (timeout_reg != '0)
                            && (wait_inc > {1'b0, timeout_reg}))
                        begin
                            timeout_sent_reg <= 1'b1;
                            halted_reg       <= exit_reg;
                            out_valid_reg    <= 1'b1;
                        end
                    end
                    else if (is_tick)
                    begin
                        begun_reg    <= 1'b1;
                        motion_reg   <= (elapsed == COUNT_MAX) ? elapsed
                                        : elapsed + CNT_W'(1);
                        alpha_ok_reg <= (move_reg == '0);
                        tol_ok_reg   <= '1;
                        arm_reg      <= '0;
                        joint_reg    <= '0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (err_abs > {2'b00, tol_reg})
                        tol_ok_reg[arm_reg[0]] <= 1'b0;
                    if (joint_reg == 3'(JOINTS - 1))
                    begin
                        joint_reg <= '0;
                        if (arm_reg == 2'(ARMS - 1))
                        begin
                            arm_reg   <= '0;
                            state_reg <= S_DIVW;
                        end
                        else
                            arm_reg <= arm_reg + 2'd1;
                    end
                    else
                        joint_reg <= joint_reg + 3'd1;
                end
                S_DIVW:
                begin
                    if (alpha_ok_reg)
                    begin
                        for (int a = 0; a < ARMS; a++)
                            done_reg[a] <= (alpha_reg == ONE_Q16) && tol_ok_reg[a];
                        succ_emit_reg <= !success_sent_reg && (alpha_reg == ONE_Q16)
                                         && ((tol_ok_reg | ~arm_en_reg) == '1);
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (arm_reg == 2'(ARMS))
                        state_reg <= succ_emit_reg ? S_SUCC : S_IDLE;
                    else if (arm_en_reg[arm_reg[0]])
                        state_reg <= S_MUL;
                    else
                        arm_reg <= arm_reg + 2'd1;
                end
                S_MUL:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (joint_reg == 3'(JOINTS - 1))
                        begin
                            joint_reg <= '0;
                            arm_reg   <= arm_reg + 2'd1;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            joint_reg <= joint_reg + 3'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_SUCC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        success_sent_reg <= 1'b1;
                        halted_reg       <= exit_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: alpha, product and the output word.
    always_ff @(posedge clk)
    begin
        if (is_tick && !waiting && (move_reg == '0))
            alpha_reg <= ONE_Q16;
        else if (div_done)
            alpha_reg <= div_q;

        if (state_reg == S_MUL)
        begin
            prod_reg <= diff * $signed({1'b0, alpha_reg});
            s_reg    <= start_reg[cur_slot];
        end

        if ((state_reg == S_IDLE) && is_tick && waiting)
        begin
            out_reg.result_kind      <= KIND_TIMEOUT;
            out_reg.out_arm          <= 1'b0;
            out_reg.out_joint        <= '0;
            out_reg.command_position <= '0;
            out_reg.arm_done         <= 1'b0;
            out_reg.last_result      <= 1'b1;
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            out_reg.result_kind      <= KIND_COMMAND;
            out_reg.out_arm          <= arm_reg[0];
            out_reg.out_joint        <= joint_reg;
            out_reg.command_position <= s_reg + shf[POS_BITS-1:0];
            out_reg.arm_done         <= done_reg[arm_reg[0]];
            out_reg.last_result      <= (joint_reg == 3'(JOINTS - 1)) && last_arm
                                        && !succ_emit_reg;
        end
        else if ((state_reg == S_SUCC) && out_free)
        begin
            out_reg.result_kind      <= KIND_SUCCESS;
            out_reg.out_arm          <= 1'b0;
            out_reg.out_joint        <= '0;
            out_reg.command_position <= '0;
            out_reg.arm_done         <= 1'b0;
            out_reg.last_result      <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `include "joint_ramp_setpoint_sequencer_top_assert.svh"

    `JRSS_ASSERT_NEXT(a_halt_silent, halted_reg && in_acc, !out_valid_reg,
        "halted block produced a result")
    `JRSS_ASSERT_NOW(a_div_idle, div_start, !div_busy,
        "alpha divider restarted while busy")
    `JRSS_ASSERT_NOW(a_alpha_range, state_reg == S_MUL, alpha_reg <= ONE_Q16,
        "alpha above one")
    `JRSS_ASSERT_NOW(a_cmd_arm_on, state_reg == S_MUL, arm_en_reg[arm_reg[0]],
        "command for a disabled arm")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import jrss_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;

    // Predicts the commands and reports of the sequencer and checks the output words.
    class ramp_scoreboard;
        int hold_len, move_len, wait_limit, tol;
        bit [1:0] arm_en;
        bit halt_on_report;
        int staged_pos[SLOTS], cur_pos[SLOTS], start_pos[SLOTS], target_pos[SLOTS];
        bit [1:0] fb_seen;
        bit begun, timeout_sent, success_sent, halted;
        int unsigned wait_cnt, motion_cnt;
        out_word_t expected_q[$];
        int errors;

        function new();
            hold_len = 25;
            move_len = 250;
            wait_limit = 1500;
            tol = 1311;
            arm_en = 2'b11;
            halt_on_report = 1'b1;
            for (int s = 0; s < SLOTS; s++)
            begin
                staged_pos[s] = 0;
                cur_pos[s] = 0;
                start_pos[s] = 0;
                target_pos[s] = 0;
            end
            fb_seen = 0;
            begun = 0;
            timeout_sent = 0;
            success_sent = 0;
            halted = 0;
            wait_cnt = 0;
            motion_cnt = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [19:0] data);
            case (idx)
                CFG_HOLD: hold_len = data;
                CFG_MOVE: move_len = data;
                CFG_TIMEOUT: wait_limit = data;
                CFG_TOL: tol = data[18:0];
                CFG_ARM_EN: arm_en = data[1:0];
                CFG_EXIT: halt_on_report = data[0];
                default: ;
            endcase
        endfunction

        // Ramp fraction in Q1.16 for a given elapsed motion tick count.
        function longint ramp_alpha(int unsigned elapsed);
            longint ramp_ticks;
            ramp_ticks = (elapsed > hold_len) ? longint'(elapsed) - hold_len : 0;
            if (move_len == 0)
                return 65536;
            if (ramp_ticks > move_len)
                ramp_ticks = move_len;
            return (ramp_ticks * 65536) / move_len;
        endfunction

        function bit arm_within(int x);
            int d;
            for (int i = 0; i < JOINTS; i++)
            begin
                d = cur_pos[x * JOINTS + i] - target_pos[x * JOINTS + i];
                if (d < 0)
                    d = -d;
                if (d > tol)
                    return 0;
            end
            return 1;
        endfunction

        // True when the next tick would report success.
        function bit tick_finishes();
            if (halted || success_sent)
                return 0;
            if ((arm_en & ~fb_seen) != 0)
                return 0;
            if (ramp_alpha(begun ? motion_cnt : 0) != 65536)
                return 0;
            for (int x = 0; x < ARMS; x++)
                if (arm_en[x] && !arm_within(x))
                    return 0;
            return 1;
        endfunction

        function void note_input(in_word_t w);
            int a, j, p, s;
            longint alpha, diff;
            bit done, every_arm_done;
            out_word_t r, res[$];
            a = w.arm;
            j = w.joint;
            p = $signed(w.position);
            if (halted)
                return;
            if (w.req_type == REQ_FEEDBACK)
            begin
                if (j < JOINTS)
                    staged_pos[a * JOINTS + j] = p;
                if (w.last)
                begin
                    for (int i = 0; i < JOINTS; i++)
                        cur_pos[a * JOINTS + i] = staged_pos[a * JOINTS + i];
                    fb_seen[a] = 1'b1;
                end
                return;
            end
            if (w.req_type == REQ_TARGET)
            begin
                if (j < JOINTS)
                    target_pos[a * JOINTS + j] = p;
                return;
            end
            if (w.req_type != REQ_TICK)
                return;

            // Still waiting for feedback from an enabled arm.
            for (int x = 0; x < ARMS; x++)
            begin
                if (arm_en[x] && !fb_seen[x])
                begin
                    if (wait_cnt < COUNT_MAX)
                        wait_cnt++;
                    if (!timeout_sent && wait_limit > 0 && wait_cnt > wait_limit)
                    begin
                        timeout_sent = 1;
                        if (halt_on_report)
                            halted = 1;
                        r = '0;
                        r.result_kind = KIND_TIMEOUT;
                        r.last_result = 1'b1;
                        expected_q.push_back(r);
                    end
                    return;
                end
            end

            if (!begun)
            begin
                begun = 1;
                motion_cnt = 0;
                for (int x = 0; x < ARMS; x++)
                    if (arm_en[x])
                        for (int i = 0; i < JOINTS; i++)
                            start_pos[x * JOINTS + i] = cur_pos[x * JOINTS + i];
            end
            alpha = ramp_alpha(motion_cnt);
            if (motion_cnt < COUNT_MAX)
                motion_cnt++;

            // One command per joint of each enabled arm.
            every_arm_done = 1;
            for (int x = 0; x < ARMS; x++)
            begin
                if (!arm_en[x])
                    continue;
                done = (alpha == 65536) && arm_within(x);
                for (int i = 0; i < JOINTS; i++)
                begin
                    s = start_pos[x * JOINTS + i];
                    diff = longint'(target_pos[x * JOINTS + i]) - s;
                    r = '0;
                    r.result_kind = KIND_COMMAND;
                    r.out_arm = 1'(x);
                    r.out_joint = 3'(i);
                    r.command_position = 20'(s + ((diff * alpha + 32768) >>> 16));
                    r.arm_done = done;
                    res.push_back(r);
                end
                if (!done)
                    every_arm_done = 0;
            end
            if (every_arm_done && !success_sent)
            begin
                success_sent = 1;
                if (halt_on_report)
                    halted = 1;
                r = '0;
                r.result_kind = KIND_SUCCESS;
                res.push_back(r);
            end
            if (res.size() > 0)
                res[res.size() - 1].last_result = 1'b1;
            foreach (res[k])
                expected_q.push_back(res[k]);
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.result_kind !== e.result_kind)
            begin
                $error("result_kind: expected %0d, got %0d", e.result_kind, got.result_kind);
                errors++;
            end
            if (got.out_arm !== e.out_arm)
            begin
                $error("out_arm: expected %0d, got %0d", e.out_arm, got.out_arm);
                errors++;
            end
            if (got.out_joint !== e.out_joint)
            begin
                $error("out_joint: expected %0d, got %0d", e.out_joint, got.out_joint);
                errors++;
            end
            if (got.command_position !== e.command_position)
            begin
                $error("command_position: expected %0d, got %0d",
                       e.command_position, got.command_position);
                errors++;
            end
            if (got.arm_done !== e.arm_done)
            begin
                $error("arm_done: expected %0d, got %0d", e.arm_done, got.arm_done);
                errors++;
            end
            if (got.last_result !== e.last_result)
            begin
                $error("last_result: expected %0d, got %0d", e.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [19:0] cfg_data = '0;

    ramp_scoreboard sb = new();
    bit calm = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    joint_ramp_setpoint_sequencer_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Receiver side: random stall bursts, none in the final part.
    always @(negedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else
            out_ready <= 1'b1;
    end

    // Output check and watchdog on handshake activity.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word);
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic send_fields(logic [1:0] req, int a, int j, int p, int lst);
        in_word_t w;
        w.req_type = req;
        w.arm = 1'(a);
        w.joint = 3'(j);
        w.position = 20'(p);
        w.last = 1'(lst);
        send_word(w);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Wait for every expected word, then let the block settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A tick, preceded by a target change when it would otherwise finish the motion.
    task automatic send_tick();
        int x, c;
        if (sb.tick_finishes())
        begin
            x = sb.arm_en[0] ? 0 : 1;
            c = sb.cur_pos[x * JOINTS];
            send_fields(REQ_TARGET, x, 0, (c >= 0) ? c - sb.tol - 1 : c + sb.tol + 1, 0);
        end
        send_fields(REQ_TICK, $urandom_range(0, 1), $urandom_range(0, 7),
                    $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1));
    endtask

    task automatic random_phase(int count);
        int n, r, a;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            a = $urandom_range(0, 1);
            if (r < 15)
            begin
                // Full feedback set for one arm.
                for (int i = 0; i < JOINTS; i++)
                    send_fields(REQ_FEEDBACK, a, i, $urandom_range(0, 20'hFFFFF),
                                i == JOINTS - 1);
                n += JOINTS;
            end
            else if (r < 35)
            begin
                send_fields(REQ_TARGET, a, $urandom_range(0, JOINTS - 1),
                            $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1));
                n++;
            end
            else if (r < 80)
            begin
                send_tick();
                n++;
            end
            else if (r < 88)
            begin
                send_fields(REQ_FEEDBACK, a, $urandom_range(0, 7),
                            $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1));
                n++;
            end
            else if (r < 94)
            begin
                send_fields(REQ_TARGET, a, $urandom_range(0, 7),
                            $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1));
                n++;
            end
            else
                send_fields(2'd3, a, $urandom_range(0, 7),
                            $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1));
            // Occasionally hold off until the block has delivered everything.
            if ($urandom_range(0, 49) == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.expected_q.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    task automatic phase_config(int hold, int move, int tmo, int tl, int en);
        write_reg(CFG_HOLD, 20'(hold));
        write_reg(CFG_MOVE, 20'(move));
        write_reg(CFG_TIMEOUT, 20'(tmo));
        write_reg(CFG_TOL, 20'(tl));
        write_reg(CFG_ARM_EN, 20'(en));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: short timeout without halting, target and feedback extremes.
        write_reg(CFG_TIMEOUT, 20'd3);
        write_reg(CFG_EXIT, 20'd0);
        send_fields(REQ_TARGET, 0, 0, -524288, 0);
        send_fields(REQ_TARGET, 0, 1, 524287, 1);
        send_fields(REQ_TARGET, 1, 6, 12345, 0);
        send_fields(REQ_TARGET, 1, 7, 5, 0);
        send_fields(2'd3, 1, 7, -1, 1);
        for (int i = 0; i < JOINTS; i++)
            send_fields(REQ_FEEDBACK, 0, i, (i % 2) ? 524287 : -524288, i == JOINTS - 1);
        repeat (5) send_tick();
        for (int i = 0; i < JOINTS; i++)
            send_fields(REQ_FEEDBACK, 1, i, i * 70001 - 200000, 0);
        // Commit through an out-of-range joint index.
        send_fields(REQ_FEEDBACK, 1, 7, 777, 1);
        repeat (3) send_tick();
        drain();

        // Random phases across a spread of settings, extremes included.
        phase_config(0, 1048575, 0, 0, 1);
        random_phase(100);
        drain();
        phase_config(1048575, 0, 1048575, 524287, 2);
        random_phase(100);
        drain();
        phase_config($urandom_range(0, 200), $urandom_range(1, 300), 1048575,
                     $urandom_range(0, 524287), 3);
        random_phase(100);
        drain();
        repeat (2)
        begin
            phase_config($urandom_range(0, 400), $urandom_range(0, 400),
                         $urandom_range(0, 1048575), $urandom_range(0, 524287),
                         $urandom_range(1, 3));
            random_phase(100);
            drain();
        end

        // Final part: targets equal the current pose, so success halts the block.
        calm = 1;
        phase_config(0, 0, 0, 524287, 3);
        write_reg(CFG_EXIT, 20'd1);
        for (int x = 0; x < ARMS; x++)
            for (int i = 0; i < JOINTS; i++)
                send_fields(REQ_TARGET, x, i, sb.cur_pos[x * JOINTS + i], 0);
        send_fields(REQ_TICK, 0, 0, 0, 0);
        // Ignored once halted.
        send_tick();
        send_fields(REQ_FEEDBACK, 0, 0, 1, 1);
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
